### design/bba_pkg.sv
// Shared constants, codes and types of the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int CNT_W          = 13;
  localparam int BLK_W          = 12;
  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;
  localparam int SCAN_WORDS     = 32;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_FULL  = 2'd1,
    ST_FREED = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREM,
    S_RD,
    S_MOD
  } state_t;

endpackage

`default_nettype wire

### design/bitmap_block_allocator.sv
// First-fit bitmap block allocator with bitmap memory and per-word full summary.
// Free: result strobe after S_FREM, S_RD and S_MOD, or from S_FREM when out of range; busy drops with
//   the strobe, so a new request is taken in the strobe cycle.
// Allocate: S_SCAN steps through c summary chunks (1 to ceil(words/32)) of the 32-word summary
//   scan; S_RD and S_MOD do the single-port read-modify-write; only S_SCAN if all words are full.
// Synchronous active-low reset marks every bitmap word invalid (reads as zero) at once.
`default_nettype none

module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_action,
  input  wire logic [bba_pkg::BLK_W-1:0]  in_block_number,
  output logic                            out_valid,
  output logic [1:0]                      out_status,
  output logic [bba_pkg::BLK_W-1:0]       out_granted_block,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bba_pkg::CNT_W-1:0]  cfg_data
);

  localparam int BLK_W     = bba_pkg::BLK_W;
  localparam int CNT_W     = bba_pkg::CNT_W;
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int SCAN_W    = bba_pkg::SCAN_WORDS;
  localparam int SEL_W     = $clog2(SCAN_W);
  localparam int N_CHUNK   = (MAP_WORDS + SCAN_W - 1) / SCAN_W;
  localparam int CH_W      = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;
  localparam int IDX_W     = $clog2(MAP_WORDS * WORD_BITS);
  localparam int CMP_W     = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int RCP_K     = BLK_W + 8;
  localparam int RCP_W     = RCP_K + 1;
  localparam int PROD_W    = BLK_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((longint'(1) << RCP_K) + longint'(WORD_BITS) - 1) / longint'(WORD_BITS));
  localparam logic [CH_W-1:0] LAST_CHUNK = CH_W'(N_CHUNK - 1);

  bba_pkg::state_t  state_r, state_nxt;
  bba_pkg::action_t action_r, action_nxt;
  bba_pkg::status_t out_status_r, out_status_nxt;

  logic [BLK_W-1:0]     blk_r, blk_nxt;
  logic                 rng_ok_r, rng_ok_nxt;
  logic [WA_W-1:0]      quo_r, quo_nxt;
  logic [CH_W-1:0]      chunk_r, chunk_nxt;
  logic [WA_W-1:0]      word_r, word_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  logic [IDX_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]     cfg_r, cfg_nxt;
  logic [MAP_WORDS-1:0] full_r, full_nxt;
  logic [MAP_WORDS-1:0] vld_r, vld_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]     out_granted_r, out_granted_nxt;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 mem_re;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]              eff_cnt;
  logic [PROD_W-1:0]             prod;
  logic [BLK_W-1:0]              rem_full;
  logic [N_CHUNK*SCAN_W-1:0]     full_pad;
  logic [SCAN_W-1:0]             nf;
  logic [SEL_W-1:0]              sel;
  logic [WORD_BITS-1:0]          wd;
  logic [WORD_BITS-1:0]          free_bits;
  logic [BIT_W-1:0]              bsel;
  logic [WORD_BITS-1:0]          bmask;
  logic [WORD_BITS-1:0]          fmask;
  logic [CMP_W-1:0]              sum;

  assign busy              = (state_r != bba_pkg::S_IDLE);
  assign cfg_ready         = (state_r == bba_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;

  assign eff_cnt  = (32'(cfg_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_r;
  assign prod     = PROD_W'(in_block_number) * PROD_W'(RECIP);
  assign rem_full = blk_r - BLK_W'(int'(quo_r) * WORD_BITS);

  always_comb begin
    full_pad = '1;
    full_pad[MAP_WORDS-1:0] = full_r;
    nf = ~full_pad[int'(chunk_r) * SCAN_W +: SCAN_W];
    sel = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (nf[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  always_comb begin
    wd = vld_r[word_r] ? rdata_r : '0;
    free_bits = ~wd;
    bsel = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        bsel = BIT_W'(i);
      end
    end
    bmask = WORD_BITS'(1) << bsel;
    fmask = WORD_BITS'(1) << bit_r;
    sum   = CMP_W'(base_r) + CMP_W'(bsel);
  end

  always_comb begin
    state_nxt       = state_r;
    action_nxt      = action_r;
    blk_nxt         = blk_r;
    rng_ok_nxt      = rng_ok_r;
    quo_nxt         = quo_r;
    chunk_nxt       = chunk_r;
    word_nxt        = word_r;
    bit_nxt         = bit_r;
    base_nxt        = base_r;
    cfg_nxt         = cfg_r;
    full_nxt        = full_r;
    vld_nxt         = vld_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_wdata       = wd;

    if (cfg_valid && cfg_ready) begin
      cfg_nxt = cfg_data;
    end

    case (state_r)
      bba_pkg::S_IDLE: begin
        if (start) begin
          action_nxt = bba_pkg::action_t'(in_action);
          blk_nxt    = in_block_number;
          rng_ok_nxt = (CNT_W'(in_block_number) < eff_cnt);
          quo_nxt    = prod[RCP_K +: WA_W];
          chunk_nxt  = '0;
          state_nxt  = (in_action == bba_pkg::ACT_FREE) ? bba_pkg::S_FREM : bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        if (|nf) begin
          word_nxt  = WA_W'(int'(chunk_r) * SCAN_W + int'(sel));
          state_nxt = bba_pkg::S_RD;
        end else if (chunk_r == LAST_CHUNK) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = bba_pkg::ST_FULL;
          out_granted_nxt = '0;
          state_nxt       = bba_pkg::S_IDLE;
        end else begin
          chunk_nxt = chunk_r + CH_W'(1);
        end
      end
      bba_pkg::S_FREM: begin
        if (rng_ok_r) begin
          word_nxt  = quo_r;
          bit_nxt   = rem_full[BIT_W-1:0];
          state_nxt = bba_pkg::S_RD;
        end else begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = bba_pkg::ST_RANGE;
          out_granted_nxt = '0;
          state_nxt       = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_RD: begin
        mem_re    = 1'b1;
        base_nxt  = IDX_W'(int'(word_r) * WORD_BITS);
        state_nxt = bba_pkg::S_MOD;
      end
      bba_pkg::S_MOD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = bba_pkg::S_IDLE;
        if (action_r == bba_pkg::ACT_FREE) begin
          mem_we           = 1'b1;
          mem_wdata        = wd & ~fmask;
          full_nxt[word_r] = 1'b0;
          vld_nxt[word_r]  = 1'b1;
          out_status_nxt   = bba_pkg::ST_FREED;
          out_granted_nxt  = '0;
        end else if (sum < CMP_W'(eff_cnt)) begin
          mem_we           = 1'b1;
          mem_wdata        = wd | bmask;
          full_nxt[word_r] = &(wd | bmask);
          vld_nxt[word_r]  = 1'b1;
          out_status_nxt   = bba_pkg::ST_ALLOC;
          out_granted_nxt  = sum[BLK_W-1:0];
        end else begin
          out_status_nxt  = bba_pkg::ST_FULL;
          out_granted_nxt = '0;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bba_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= CNT_W'(4096);
      full_r      <= '0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      full_r      <= full_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r      <= action_nxt;
    blk_r         <= blk_nxt;
    rng_ok_r      <= rng_ok_nxt;
    quo_r         <= quo_nxt;
    chunk_r       <= chunk_nxt;
    word_r        <= word_nxt;
    bit_r         <= bit_nxt;
    base_r        <= base_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[word_r];
    end
  end

endmodule

`default_nettype wire

### design/bba_checker.sv
// Port-level assertions for the bitmap block allocator, bound to the top level.
`default_nettype none

module bba_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic [1:0]                out_status,
  input wire logic [bba_pkg::BLK_W-1:0] out_granted_block
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result word");

  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bba_pkg::ST_ALLOC) |-> out_granted_block == '0)
    else $error("nonzero block number on a non-allocate result");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire

### sim/tb_bitmap_block_allocator.sv
// Testbench of the bitmap block allocator: directed table, then random phases.
`default_nettype none

module tb_bitmap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK_W  = bba_pkg::BLK_W;
  localparam int CNT_W  = bba_pkg::CNT_W;
  localparam int MAXB   = bba_pkg::MAX_BLOCKS_DEF;
  localparam int SETTLE = 10;
  localparam int LIMIT  = 2000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    bba_pkg::status_t status;
    logic [BLK_W-1:0] granted;
  } reply_t;

  typedef struct packed {
    bit               is_cfg;
    bba_pkg::action_t act;
    logic [CNT_W-1:0] value;
    bit               typed;
    bba_pkg::status_t st;
    logic [BLK_W-1:0] granted;
  } step_t;

  localparam step_t SCRIPT [23] = '{
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b1, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b1, bba_pkg::ST_ALLOC, 12'd1},
    '{1'b0, bba_pkg::ACT_FREE,  13'd4095, 1'b1, bba_pkg::ST_FREED, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd0,    1'b1, bba_pkg::ST_FREED, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b1, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd4095, 1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b1, bba_pkg::ACT_ALLOC, 13'd2,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b1, bba_pkg::ST_FULL,  12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd2,    1'b1, bba_pkg::ST_RANGE, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd1,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b1, bba_pkg::ACT_ALLOC, 13'd0,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b1, bba_pkg::ST_FULL,  12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd0,    1'b1, bba_pkg::ST_RANGE, 12'd0},
    '{1'b1, bba_pkg::ACT_ALLOC, 13'd8191, 1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd4095, 1'b1, bba_pkg::ST_FREED, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b1, bba_pkg::ACT_ALLOC, 13'd4096, 1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd2,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_ALLOC, 13'd0,    1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b1, bba_pkg::ACT_ALLOC, 13'd4095, 1'b0, bba_pkg::ST_ALLOC, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd4095, 1'b1, bba_pkg::ST_RANGE, 12'd0},
    '{1'b0, bba_pkg::ACT_FREE,  13'd4094, 1'b1, bba_pkg::ST_FREED, 12'd0}
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  bba_pkg::action_t in_action;
  logic [BLK_W-1:0] in_block_number;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [BLK_W-1:0] out_granted_block;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  logic [MAXB-1:0]  block_map = '0;
  logic [CNT_W-1:0] managed_count = 13'd4096;
  int               hi_mark = 0;
  reply_t           awaited_replies [$];
  bit               hint_typed;
  reply_t           hint_reply;
  int               mismatches = 0;
  int               quiet_cycles = 0;

  bitmap_block_allocator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic reply_t first_fit_reply(bba_pkg::action_t act, logic [BLK_W-1:0] blk);
    reply_t r;
    int     lim;
    bit     found;
    lim = (managed_count > MAXB) ? MAXB : int'(managed_count);
    found = 1'b0;
    r.granted = '0;
    if (act == bba_pkg::ACT_ALLOC) begin
      r.status = bba_pkg::ST_FULL;
      for (int i = 0; i < lim && !found; i++) begin
        if (!block_map[i]) begin
          block_map[i] = 1'b1;
          r.status = bba_pkg::ST_ALLOC;
          r.granted = BLK_W'(i);
          found = 1'b1;
          if (i > hi_mark) hi_mark = i;
        end
      end
    end else if (int'(blk) < lim) begin
      block_map[blk] = 1'b0;
      r.status = bba_pkg::ST_FREED;
    end else begin
      r.status = bba_pkg::ST_RANGE;
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    reply_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: status %0d granted %0d", out_status, out_granted_block);
        end else begin
          want = awaited_replies.pop_front();
          if (out_status !== want.status || out_granted_block !== want.granted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: status exp %0d got %0d, granted exp %0d got %0d",
                       want.status, out_status, want.granted, out_granted_block);
          end
        end
      end
      if (start && !busy) begin
        want = first_fit_reply(in_action, in_block_number);
        if (hint_typed) want = hint_reply;
        awaited_replies.push_back(want);
      end
      if (cfg_valid && cfg_ready) managed_count = cfg_data;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(bba_pkg::action_t act, logic [BLK_W-1:0] blk, bit typed,
                           reply_t typed_reply, bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start = 1'b1;
    in_action = act;
    in_block_number = blk;
    hint_typed = typed;
    hint_reply = typed_reply;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    start = 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value, bit may_idle);
    hold_until_drained();
    if (may_idle) repeat ($urandom_range(1, 17)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0] counts [PHASES];
    logic [CNT_W-1:0] phase_count;
    int               eff;
    int               top;
    int               sel;
    bit               idle_on;
    logic [BLK_W-1:0] blk;
    bba_pkg::action_t act;
    reply_t           typed_reply;

    rst_n = 1'b0;
    start = 1'b0;
    in_action = bba_pkg::ACT_ALLOC;
    in_block_number = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hint_typed = 1'b0;
    hint_reply = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        write_count(SCRIPT[i].value, 1'b1);
      end else begin
        typed_reply.status = SCRIPT[i].st;
        typed_reply.granted = SCRIPT[i].granted;
        send_word(SCRIPT[i].act, SCRIPT[i].value[BLK_W-1:0], SCRIPT[i].typed, typed_reply, 1'b1);
      end
    end

    counts = '{13'd1, 13'd7, 13'd32, 13'd33, 13'd0, 13'd8191, 13'd100,
               CNT_W'($urandom_range(1, 300)), 13'd64, 13'd4096};
    for (int p = 0; p < PHASES; p++) begin
      phase_count = counts[p];
      eff = (phase_count > MAXB) ? MAXB : int'(phase_count);
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 4) != 0);
      write_count(phase_count, idle_on);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) hold_until_drained();
        act = ($urandom_range(0, 9) < 5) ? bba_pkg::ACT_ALLOC : bba_pkg::ACT_FREE;
        sel = $urandom_range(0, 19);
        top = (eff < hi_mark + 2) ? eff : hi_mark + 2;
        if (top > MAXB - 1) top = MAXB - 1;
        if (sel < 14)
          blk = BLK_W'($urandom_range(0, top));
        else if (sel < 17)
          blk = BLK_W'((eff == 0) ? 0 : eff - $urandom_range(0, 1));
        else
          blk = BLK_W'($urandom_range(0, MAXB - 1));
        send_word(act, blk, 1'b0, '0, idle_on);
      end
    end

    hold_until_drained();
    mismatches += awaited_replies.size();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/bba_pkg.sv
design/bitmap_block_allocator.sv
design/bba_checker.sv
sim/tb_bitmap_block_allocator.sv
